// ===== rtl/core/buddy_block_allocator_macros.svh =====
// Assertion helpers shared by the checker of the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define BBA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// Next-cycle implication, switched off while reset is held.
`define BBA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] req_size;
        logic [31:0] block_offset;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_offset;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_TOO_BIG = 3'd2,
        ST_NO_MEM  = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    localparam logic       ACT_ALLOC     = 1'b0;
    localparam logic       ACT_FREE      = 1'b1;
    localparam logic [0:0] CFG_MIN_LOG2  = 1'b0;
    localparam logic [0:0] CFG_MAX_LEVEL = 1'b1;
    localparam logic [4:0] RST_MIN_LOG2  = 5'd6;
    localparam logic [3:0] RST_MAX_LEVEL = 4'd10;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_FAIL,
        OP_LVL_INC,
        OP_SCAN_INIT,
        OP_SCAN_INC,
        OP_POP,
        OP_TAKE,
        OP_SPLIT,
        OP_GRANT,
        OP_FREAD,
        OP_FTAKE,
        OP_SRCH_INIT,
        OP_SRD,
        OP_K_INC,
        OP_MRD,
        OP_MWR,
        OP_MERGE,
        OP_PUSH,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LEVEL,
        S_SCAN,
        S_TAKE,
        S_SPLIT,
        S_FTAKE,
        S_LOOP,
        S_SRD,
        S_SCMP,
        S_MRD,
        S_MWR,
        S_PUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic err_zero;
        logic err_big;
        logic err_range;
        logic lvl_done;
        logic scan_hit;
        logic scan_end;
        logic split_done;
        logic g_valid;
        logic at_top;
        logic srch_end;
        logic srch_hit;
        logic mv_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/buddy_block_allocator.sv =====
// Buddy block allocator over a region of 2^(min_block_log2 + max_level) bytes.
// Requests arrive as words on the input channel (i_in_valid, o_in_stall,
// i_in_word); every request yields one result word on the output channel
// (o_out_valid, i_out_stall, o_out_word) with a status and, for a successful
// allocate, the granted byte offset. One request is worked on at a time.
// A successful allocate walks up the levels while rounding the size, scans
// the levels for a free block and then splits it down level by level. A
// failed size check answers straight from the check, a free of an unrecorded
// block after its grant-map entry is read. A successful free merges level by
// level, searching the free stack for the buddy entry by entry and moving the
// later entries down, until merging stops, and then pushes the block. The
// free-stack memory has a single port; the input is ready again as the
// result word is registered.
// After reset, and after any configuration write, a clearing pass over every
// grant-map entry wipes the grant map and seeds one free block at the top
// level; no request is taken during it.
// A finished result sits in an output register. While the receiver stalls,
// that word holds steady and the next request may still be taken and worked
// on; it then waits for the register to drain before it is delivered.
module buddy_block_allocator #(
    parameter int MAX_LEVELS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bba_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bba_pkg::t_out_word o_out_word
);

    // Commands flow from the sequencer to the datapath, flags flow back.
    bba_pkg::t_dp_cmd  cmd;
    bba_pkg::t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the free stacks, the grant map, the configuration
    // registers and the output register.
    bba_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/core/bba_ctrl.sv =====
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cfg_we,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_CLEAR: if (i_stat.clr_last) n_state = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE:  if (i_in_valid) n_state = bba_pkg::S_CHECK;
            bba_pkg::S_CHECK: begin
                if (i_stat.is_free) begin
                    n_state = i_stat.err_range ? bba_pkg::S_DONE : bba_pkg::S_FTAKE;
                end else begin
                    n_state = (i_stat.err_zero || i_stat.err_big) ? bba_pkg::S_DONE
                                                                   : bba_pkg::S_LEVEL;
                end
            end
            bba_pkg::S_LEVEL: if (i_stat.lvl_done) n_state = bba_pkg::S_SCAN;
            bba_pkg::S_SCAN: begin
                if (i_stat.scan_hit) n_state = bba_pkg::S_TAKE;
                else if (i_stat.scan_end) n_state = bba_pkg::S_DONE;
            end
            bba_pkg::S_TAKE:  n_state = bba_pkg::S_SPLIT;
            bba_pkg::S_SPLIT: if (i_stat.split_done) n_state = bba_pkg::S_DONE;
            bba_pkg::S_FTAKE: n_state = i_stat.g_valid ? bba_pkg::S_LOOP : bba_pkg::S_DONE;
            bba_pkg::S_LOOP:  n_state = i_stat.at_top ? bba_pkg::S_PUSH : bba_pkg::S_SRD;
            bba_pkg::S_SRD:   n_state = i_stat.srch_end ? bba_pkg::S_PUSH : bba_pkg::S_SCMP;
            bba_pkg::S_SCMP:  n_state = i_stat.srch_hit ? bba_pkg::S_MRD : bba_pkg::S_SRD;
            bba_pkg::S_MRD:   n_state = i_stat.mv_end ? bba_pkg::S_LOOP : bba_pkg::S_MWR;
            bba_pkg::S_MWR:   n_state = bba_pkg::S_MRD;
            bba_pkg::S_PUSH:  n_state = bba_pkg::S_DONE;
            bba_pkg::S_DONE:  if (i_stat.out_free) n_state = bba_pkg::S_IDLE;
            default:          n_state = bba_pkg::S_CLEAR;
        endcase
        if (i_cfg_we) n_state = bba_pkg::S_CLEAR;
    end

    always_comb begin
        o_cmd.op   = bba_pkg::OP_NONE;
        o_cmd.code = bba_pkg::ST_OK;
        o_in_stall = 1'b1;
        unique case (r_state)
            bba_pkg::S_CLEAR: o_cmd.op = bba_pkg::OP_CLR;
            bba_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd.op = bba_pkg::OP_LOAD;
            end
            bba_pkg::S_CHECK: begin
                if (i_stat.is_free) begin
                    if (i_stat.err_range) begin
                        o_cmd.op   = bba_pkg::OP_FAIL;
                        o_cmd.code = bba_pkg::ST_RANGE;
                    end else begin
                        o_cmd.op = bba_pkg::OP_FREAD;
                    end
                end else if (i_stat.err_zero) begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_ZERO;
                end else if (i_stat.err_big) begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_TOO_BIG;
                end
            end
            bba_pkg::S_LEVEL: o_cmd.op = i_stat.lvl_done ? bba_pkg::OP_SCAN_INIT
                                                         : bba_pkg::OP_LVL_INC;
            bba_pkg::S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.op = bba_pkg::OP_POP;
                end else if (i_stat.scan_end) begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_NO_MEM;
                end else begin
                    o_cmd.op = bba_pkg::OP_SCAN_INC;
                end
            end
            bba_pkg::S_TAKE:  o_cmd.op = bba_pkg::OP_TAKE;
            bba_pkg::S_SPLIT: o_cmd.op = i_stat.split_done ? bba_pkg::OP_GRANT
                                                           : bba_pkg::OP_SPLIT;
            bba_pkg::S_FTAKE: begin
                if (i_stat.g_valid) begin
                    o_cmd.op = bba_pkg::OP_FTAKE;
                end else begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_RANGE;
                end
            end
            bba_pkg::S_LOOP: if (!i_stat.at_top) o_cmd.op = bba_pkg::OP_SRCH_INIT;
            bba_pkg::S_SRD:  if (!i_stat.srch_end) o_cmd.op = bba_pkg::OP_SRD;
            bba_pkg::S_SCMP: if (!i_stat.srch_hit) o_cmd.op = bba_pkg::OP_K_INC;
            bba_pkg::S_MRD:  o_cmd.op = i_stat.mv_end ? bba_pkg::OP_MERGE : bba_pkg::OP_MRD;
            bba_pkg::S_MWR:  o_cmd.op = bba_pkg::OP_MWR;
            bba_pkg::S_PUSH: o_cmd.op = bba_pkg::OP_PUSH;
            bba_pkg::S_DONE: if (i_stat.out_free) o_cmd.op = bba_pkg::OP_EMIT;
            default:         o_cmd.op = bba_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/bba_dp.sv =====
module bba_dp #(
    parameter int MAX_LEVELS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  bba_pkg::t_in_word  i_in_word,
    input  logic               i_out_stall,
    input  bba_pkg::t_dp_cmd   i_cmd,
    output bba_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output bba_pkg::t_out_word o_out_word
);

    localparam int UNITS  = 1 << MAX_LEVELS;
    localparam int LW     = $clog2(MAX_LEVELS + 1);
    localparam int UW     = MAX_LEVELS;
    localparam int CW     = MAX_LEVELS + 1;
    localparam int SAW    = LW + UW;
    localparam int SDEPTH = (MAX_LEVELS + 1) * UNITS;
    localparam int GW     = LW + 1;

    function automatic logic [LW-1:0] f_top(input logic [3:0] m);
        logic [4:0] m5;
        m5 = {1'b0, m};
        if (m5 == 5'd0) begin
            f_top = LW'(1);
        end else if (m5 > 5'(MAX_LEVELS)) begin
            f_top = LW'(MAX_LEVELS);
        end else begin
            f_top = LW'(m5);
        end
    endfunction

    // Stack storage, addressed by {level, stack position}, and the grant map.
    logic [UW-1:0] smem [0:SDEPTH-1];
    logic [GW-1:0] gmem [0:UNITS-1];

    logic [4:0]    r_min_log2;
    logic [3:0]    r_max_level;
    logic [CW-1:0] r_cnt [0:MAX_LEVELS];
    logic [UW-1:0] r_clr_idx;
    logic          r_out_valid;

    logic          r_action;
    logic [31:0]   r_size;
    logic [31:0]   r_offs;
    logic [LW-1:0] r_lvl;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_cur;
    logic [UW-1:0] r_unit;
    logic [CW-1:0] r_k;
    logic [2:0]    r_status;
    logic [31:0]   r_gofs;
    logic [UW-1:0] r_rdata;
    logic [GW-1:0] r_grd;
    bba_pkg::t_out_word r_out_word;

    logic [LW-1:0] top;
    logic [5:0]    lim;
    logic [4:0]    mlog;
    logic [32:0]   total;
    logic [32:0]   size33;
    logic [32:0]   offs33;
    logic [32:0]   end33;
    logic [32:0]   mask;
    logic [31:0]   unit_all;
    logic [UW-1:0] unit_f;
    logic [CW-1:0] cnt_i;
    logic [CW-1:0] cnt_m1;
    logic [LW-1:0] cur_m1;
    logic [CW-1:0] cnt_c;
    logic [CW-1:0] kp1;
    logic [UW-1:0] buddy;
    logic [LW-1:0] cfg_top;
    logic [LW-1:0] g_lvl;

    logic          s_we;
    logic          s_re;
    logic [SAW-1:0] s_addr;
    logic [UW-1:0] s_wdata;
    logic          g_we;
    logic          g_re;
    logic [UW-1:0] g_addr;
    logic [GW-1:0] g_wdata;

    assign top      = f_top(r_max_level);
    assign lim      = 6'd32 - 6'(top);
    assign mlog     = ({1'b0, r_min_log2} > lim) ? lim[4:0] : r_min_log2;
    assign total    = 33'd1 << (6'(mlog) + 6'(top));
    assign size33   = {1'b0, r_size};
    assign offs33   = {1'b0, r_offs};
    assign end33    = offs33 + size33;
    assign mask     = (33'd1 << mlog) - 33'd1;
    assign unit_all = r_offs >> mlog;
    assign unit_f   = unit_all[UW-1:0];
    assign cnt_i    = r_cnt[r_i];
    assign cnt_m1   = cnt_i - CW'(1);
    assign cur_m1   = r_cur - LW'(1);
    assign cnt_c    = r_cnt[cur_m1];
    assign kp1      = r_k + CW'(1);
    assign buddy    = r_unit ^ (UW'(1) << r_i);
    assign g_lvl    = (r_grd[LW-1:0] > top) ? top : r_grd[LW-1:0];
    assign cfg_top  = (i_cfg_index == bba_pkg::CFG_MAX_LEVEL) ? f_top(i_cfg_data[3:0])
                                                              : top;

    assign o_stat.clr_last   = &r_clr_idx;
    assign o_stat.is_free    = (r_action == bba_pkg::ACT_FREE);
    assign o_stat.err_zero   = (r_size == 32'd0);
    assign o_stat.err_big    = (size33 > total);
    assign o_stat.err_range  = (size33 > total) || (end33 > total) ||
                               ((offs33 & mask) != 33'd0) ||
                               ({1'b0, unit_all} >= (33'd1 << top));
    assign o_stat.lvl_done   = (r_lvl == top) ||
                               ((33'd1 << (6'(mlog) + 6'(r_lvl))) >= size33);
    assign o_stat.scan_hit   = (cnt_i != '0);
    assign o_stat.scan_end   = (r_i == top);
    assign o_stat.split_done = (r_cur == r_lvl);
    assign o_stat.g_valid    = r_grd[LW];
    assign o_stat.at_top     = (r_i >= top);
    assign o_stat.srch_end   = (r_k >= cnt_i);
    assign o_stat.srch_hit   = (r_rdata == buddy);
    assign o_stat.mv_end     = (kp1 >= cnt_i);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        s_we    = 1'b0;
        s_re    = 1'b0;
        s_addr  = {r_i, r_k[UW-1:0]};
        s_wdata = r_unit;
        g_we    = 1'b0;
        g_re    = 1'b0;
        g_addr  = r_unit;
        g_wdata = {1'b1, r_lvl};
        unique case (i_cmd.op)
            bba_pkg::OP_CLR: begin
                s_we    = (r_clr_idx == '0);
                s_addr  = {top, UW'(0)};
                s_wdata = '0;
                g_we    = 1'b1;
                g_addr  = r_clr_idx;
                g_wdata = '0;
            end
            bba_pkg::OP_POP: begin
                s_re   = 1'b1;
                s_addr = {r_i, cnt_m1[UW-1:0]};
            end
            bba_pkg::OP_SPLIT: begin
                s_we    = (cnt_c < CW'(UNITS));
                s_addr  = {cur_m1, cnt_c[UW-1:0]};
                s_wdata = r_unit + (UW'(1) << cur_m1);
            end
            bba_pkg::OP_GRANT: g_we = 1'b1;
            bba_pkg::OP_FREAD: begin
                g_re   = 1'b1;
                g_addr = unit_f;
            end
            bba_pkg::OP_FTAKE: begin
                g_we    = 1'b1;
                g_addr  = unit_f;
                g_wdata = {1'b0, r_grd[LW-1:0]};
            end
            bba_pkg::OP_SRD: s_re = 1'b1;
            bba_pkg::OP_MRD: begin
                s_re   = 1'b1;
                s_addr = {r_i, kp1[UW-1:0]};
            end
            bba_pkg::OP_MWR: begin
                s_we    = 1'b1;
                s_wdata = r_rdata;
            end
            bba_pkg::OP_PUSH: begin
                s_we   = (cnt_i < CW'(UNITS));
                s_addr = {r_i, cnt_i[UW-1:0]};
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) smem[s_addr] <= s_wdata;
        if (s_re) r_rdata <= smem[s_addr];
        if (g_we) gmem[g_addr] <= g_wdata;
        if (g_re) r_grd <= gmem[g_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_log2  <= bba_pkg::RST_MIN_LOG2;
            r_max_level <= bba_pkg::RST_MAX_LEVEL;
            for (int l = 0; l <= MAX_LEVELS; l++) begin
                r_cnt[l] <= (LW'(l) == f_top(bba_pkg::RST_MAX_LEVEL)) ? CW'(1) : '0;
            end
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bba_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == bba_pkg::CFG_MIN_LOG2) begin
                    r_min_log2 <= i_cfg_data;
                end else begin
                    r_max_level <= i_cfg_data[3:0];
                end
                for (int l = 0; l <= MAX_LEVELS; l++) begin
                    r_cnt[l] <= (LW'(l) == cfg_top) ? CW'(1) : '0;
                end
                r_clr_idx      <= '0;
            end else begin
                unique case (i_cmd.op)
                    bba_pkg::OP_CLR:   r_clr_idx <= r_clr_idx + UW'(1);
                    bba_pkg::OP_POP:   r_cnt[r_i] <= cnt_m1;
                    bba_pkg::OP_MERGE: r_cnt[r_i] <= cnt_m1;
                    bba_pkg::OP_SPLIT: begin
                        if (cnt_c < CW'(UNITS)) r_cnt[cur_m1] <= cnt_c + CW'(1);
                    end
                    bba_pkg::OP_PUSH: begin
                        if (cnt_i < CW'(UNITS)) r_cnt[r_i] <= cnt_i + CW'(1);
                    end
                    default: begin
                        r_clr_idx <= r_clr_idx;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bba_pkg::OP_LOAD: begin
                r_action <= i_in_word.action;
                r_size   <= i_in_word.req_size;
                r_offs   <= i_in_word.block_offset;
                r_lvl    <= '0;
            end
            bba_pkg::OP_FAIL: begin
                r_status <= i_cmd.code;
                r_gofs   <= '0;
            end
            bba_pkg::OP_LVL_INC:   r_lvl <= r_lvl + LW'(1);
            bba_pkg::OP_SCAN_INIT: r_i <= r_lvl;
            bba_pkg::OP_SCAN_INC:  r_i <= r_i + LW'(1);
            bba_pkg::OP_TAKE: begin
                r_unit <= r_rdata;
                r_cur  <= r_i;
            end
            bba_pkg::OP_SPLIT: r_cur <= cur_m1;
            bba_pkg::OP_GRANT: begin
                r_status <= bba_pkg::ST_OK;
                r_gofs   <= 32'(r_unit) << mlog;
            end
            bba_pkg::OP_FTAKE: begin
                r_unit <= unit_f;
                r_i    <= g_lvl;
            end
            bba_pkg::OP_SRCH_INIT: r_k <= '0;
            bba_pkg::OP_K_INC:     r_k <= kp1;
            bba_pkg::OP_MWR:       r_k <= kp1;
            bba_pkg::OP_MERGE: begin
                r_unit <= (buddy < r_unit) ? buddy : r_unit;
                r_i    <= r_i + LW'(1);
            end
            bba_pkg::OP_PUSH: begin
                r_status <= bba_pkg::ST_OK;
                r_gofs   <= '0;
            end
            bba_pkg::OP_EMIT: begin
                r_out_word.status         <= r_status;
                r_out_word.granted_offset <= r_gofs;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/bba_checker.sv =====
`include "buddy_block_allocator_macros.svh"

module bba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bba_pkg::t_out_word o_out_word
);

    // A taken request keeps the block busy in the following cycle.
    `BBA_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // A configuration write starts the clearing pass.
    `BBA_ASSERT_NXT(a_busy_after_cfg, i_cfg_we, o_in_stall)

    // Only a successful allocate reports a non-zero offset.
    `BBA_ASSERT_IMP(a_fail_zero_offset,
        o_out_valid && (o_out_word.status != bba_pkg::ST_OK),
        o_out_word.granted_offset == 32'd0)

    // A stalled result word holds.
    `BBA_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_word))

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

// ===== verif/buddy_block_allocator_checker.sv =====
// Watches both channels and the register port of the allocator, keeps its own
// model of the free stacks and the grant map, and compares every result word.
module buddy_block_allocator_checker #(
    parameter int MAX_LEVELS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  bba_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  bba_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = 1 << MAX_LEVELS;

    logic [4:0] min_log2_q;
    logic [3:0] max_level_q;
    logic [MAX_LEVELS-1:0] stack_mem [0:MAX_LEVELS][0:UNITS-1];
    int                    stack_depth [0:MAX_LEVELS];
    logic [3:0]            grant_lvl [0:UNITS-1];
    logic                  grant_live [0:UNITS-1];
    bba_pkg::t_out_word    awaited_q [$];

    assign o_pending = awaited_q.size();

    function automatic int levels_in_use();
        if (max_level_q < 1) return 1;
        if (max_level_q > MAX_LEVELS) return MAX_LEVELS;
        return int'(max_level_q);
    endfunction

    function automatic int unit_log2();
        int lim;
        lim = 32 - levels_in_use();
        return (int'(min_log2_q) > lim) ? lim : int'(min_log2_q);
    endfunction

    task automatic push_block(input int lvl, input int unit);
        if (lvl > MAX_LEVELS || stack_depth[lvl] >= UNITS) return;
        stack_mem[lvl][stack_depth[lvl]] = unit[MAX_LEVELS-1:0];
        stack_depth[lvl]++;
    endtask

    task automatic wipe_pool();
        for (int l = 0; l <= MAX_LEVELS; l++) stack_depth[l] = 0;
        for (int u = 0; u < UNITS; u++) begin
            grant_lvl[u] = '0;
            grant_live[u] = 1'b0;
        end
        push_block(levels_in_use(), 0);
    endtask

    // Works out the result of one request and updates the pool as the block would.
    task automatic serve_request(input bba_pkg::t_in_word w, output bba_pkg::t_out_word r);
        int top, mlog, lvl, unit, buddy, n, k;
        longint unsigned total, size, offs, unit64;
        bit found;
        top = levels_in_use();
        mlog = unit_log2();
        total = 64'd1 << (mlog + top);
        size = w.req_size;
        offs = w.block_offset;
        r.status = bba_pkg::ST_OK;
        r.granted_offset = '0;
        if (w.action != bba_pkg::ACT_FREE) begin
            if (size == 0) r.status = bba_pkg::ST_ZERO;
            else if (size > total) r.status = bba_pkg::ST_TOO_BIG;
            else begin
                lvl = 0;
                while ((64'd1 << (mlog + lvl)) < size && lvl < top) lvl++;
                r.status = bba_pkg::ST_NO_MEM;
                for (int i = lvl; i <= top; i++) begin
                    if (stack_depth[i] == 0) continue;
                    stack_depth[i]--;
                    unit = int'(stack_mem[i][stack_depth[i]]);
                    for (int c = i - 1; c >= lvl; c--) push_block(c, unit + (1 << c));
                    grant_lvl[unit] = lvl[3:0];
                    grant_live[unit] = 1'b1;
                    r.granted_offset = 32'(64'(unit) << mlog);
                    r.status = bba_pkg::ST_OK;
                    break;
                end
            end
        end else begin
            unit64 = offs >> mlog;
            if (size > total || offs + size > total ||
                (offs & ((64'd1 << mlog) - 1)) != 0 ||
                unit64 >= (64'd1 << top) || !grant_live[unit64[MAX_LEVELS-1:0]]) begin
                r.status = bba_pkg::ST_RANGE;
            end else begin
                unit = int'(unit64);
                lvl = int'(grant_lvl[unit]);
                grant_live[unit] = 1'b0;
                if (lvl > top) lvl = top;
                while (lvl < top) begin
                    buddy = unit ^ (1 << lvl);
                    n = stack_depth[lvl];
                    found = 0;
                    for (k = 0; k < n; k++) begin
                        if (int'(stack_mem[lvl][k]) == buddy) begin
                            found = 1;
                            break;
                        end
                    end
                    if (!found) break;
                    for (int j = k; j < n - 1; j++) stack_mem[lvl][j] = stack_mem[lvl][j+1];
                    stack_depth[lvl] = n - 1;
                    if (buddy < unit) unit = buddy;
                    lvl++;
                end
                push_block(lvl, unit);
            end
        end
    endtask

    always @(posedge i_clk) begin
        bba_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            min_log2_q = bba_pkg::RST_MIN_LOG2;
            max_level_q = bba_pkg::RST_MAX_LEVEL;
            wipe_pool();
            awaited_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bba_pkg::CFG_MIN_LOG2) min_log2_q = i_cfg_data;
                else max_level_q = i_cfg_data[3:0];
                wipe_pool();
            end
            if (i_in_valid && !i_in_stall) begin
                serve_request(i_in_word, exp_w);
                awaited_q.push_back(exp_w);
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result word status %0d offset %h", $realtime,
                             i_out_word.status, i_out_word.granted_offset);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = awaited_q.pop_front();
                    if (exp_w !== i_out_word) begin
                        $display({"%0t: mismatch expected status %0d offset %h, ",
                                  "got status %0d offset %h"},
                                 $realtime, exp_w.status, exp_w.granted_offset,
                                 i_out_word.status, i_out_word.granted_offset);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    initial o_fail_count = 0;
endmodule

// ===== verif/buddy_block_allocator_tb.sv =====
// Top of the allocator testbench: clock, reset, register writes, request
// words and the output stall. All checking is done by the checker module; this
// module only builds stimulus and gives the verdict.
module buddy_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEVELS = 10;
    localparam longint CYCLE_LIMIT = 6_000_000;

    typedef struct {
        logic [31:0] offs;
        logic [31:0] size;
    } t_grant;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [4:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    bba_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    bba_pkg::t_out_word o_out_word;
    int                 fail_count;
    int                 pending;

    // Stimulus bookkeeping: requests in flight, and grants that may be freed.
    bba_pkg::t_in_word  inflight_q [$];
    t_grant             held_q [$];
    int                 idle_pct;
    int                 stall_pct;
    int                 pool_levels;
    int                 pool_log2;
    longint             cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    buddy_block_allocator #(.MAX_LEVELS(MAX_LEVELS)) i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_in_word,
        .o_out_valid, .i_out_stall, .o_out_word
    );

    buddy_block_allocator_checker #(.MAX_LEVELS(MAX_LEVELS)) i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_in_word,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_word(o_out_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Follows the words through the block so that frees can name live grants.
    always @(posedge i_clk) begin
        bba_pkg::t_in_word req;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) inflight_q.push_back(i_in_word);
            if (o_out_valid && !i_out_stall && inflight_q.size() != 0) begin
                req = inflight_q.pop_front();
                if (req.action != bba_pkg::ACT_FREE && o_out_word.status == bba_pkg::ST_OK)
                    held_q.push_back('{o_out_word.granted_offset, req.req_size});
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("buddy_block_allocator regression: fail");
            $finish;
        end
    end

    // Presents one word and holds it until the block takes it. The stall seen
    // at the falling edge is the one that the next rising edge will act on.
    task automatic send_word(input logic act, input logic [31:0] size,
                             input logic [31:0] offs);
        logic st;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_word <= '{action: 1'($urandom), req_size: $urandom, block_offset: $urandom};
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= '{action: act, req_size: size, block_offset: offs};
        do begin
            @(negedge i_clk);
            st = o_in_stall;
            @(posedge i_clk);
        end while (st);
    endtask

    // Waits until every result has come back, then lets the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0 || inflight_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Writes both registers; each write starts a fresh clearing pass, which
    // the block signals by stalling its input.
    task automatic set_pool(input logic [4:0] log2_val, input logic [4:0] level_val);
        int lv;
        i_cfg_we <= 1'b1;
        i_cfg_index <= bba_pkg::CFG_MIN_LOG2;
        i_cfg_data <= log2_val;
        @(posedge i_clk);
        i_cfg_index <= bba_pkg::CFG_MAX_LEVEL;
        i_cfg_data <= level_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        held_q.delete();
        lv = int'(level_val[3:0]);
        pool_levels = (lv < 1) ? 1 : (lv > MAX_LEVELS) ? MAX_LEVELS : lv;
        pool_log2 = (int'(log2_val) > 32 - pool_levels) ? 32 - pool_levels : int'(log2_val);
    endtask

    // One random request: mostly well-formed allocate and free pairs, the rest
    // noise, broken frees and frees of blocks already returned.
    task automatic random_request();
        int kind, lvl, b, pick;
        logic [31:0] hi, size, offs;
        t_grant g;
        kind = $urandom_range(99);
        if (kind < 40 || (kind < 75 && held_q.size() == 0)) begin
            lvl = (pool_levels > 4 && $urandom_range(3) != 0) ?
                  $urandom_range(3) : $urandom_range(pool_levels);
            b = pool_log2 + lvl;
            hi = (b >= 32) ? 32'hFFFF_FFFF : 32'(64'd1 << b);
            size = ($urandom_range(4) == 0) ? hi : $urandom_range(hi, 1);
            send_word(bba_pkg::ACT_ALLOC, size, $urandom);
        end else if (kind < 75) begin
            pick = $urandom_range(held_q.size() - 1);
            g = held_q[pick];
            held_q.delete(pick);
            send_word(bba_pkg::ACT_FREE, g.size, g.offs);
            // Occasionally free the same block again straight away.
            if ($urandom_range(9) == 0) send_word(bba_pkg::ACT_FREE, g.size, g.offs);
        end else if (kind < 85) begin
            send_word(1'($urandom), $urandom, $urandom);
        end else if (kind < 92) begin
            offs = 32'($urandom_range((1 << pool_levels) - 1)) << pool_log2;
            if ($urandom_range(1) == 0) offs = offs | 32'($urandom_range(3));
            send_word(bba_pkg::ACT_FREE, $urandom_range(64), offs);
        end else begin
            send_word(bba_pkg::ACT_ALLOC, ($urandom_range(1) == 0) ? 32'd0 : $urandom,
                      $urandom);
        end
    endtask

    initial begin
        logic [4:0] log2_set  [8];
        logic [4:0] level_set [8];
        log2_set  = '{5'd6, 5'd0, 5'd22, 5'd31, 5'd0, 5'd3, 5'd22, 5'd10};
        level_set = '{5'd10, 5'd1, 5'd10, 5'd15, 5'd0, 5'd4, 5'd1, 5'd10};
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        pool_levels = MAX_LEVELS;
        pool_log2 = int'(bba_pkg::RST_MIN_LOG2);
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= bba_pkg::CFG_MIN_LOG2;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on the reset pool of 64 KiB in 64-byte units.
        send_word(bba_pkg::ACT_ALLOC, 32'd0, 32'd0);                 // zero size
        send_word(bba_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // larger than the region
        send_word(bba_pkg::ACT_ALLOC, 32'd65537, 32'd0);             // one byte too big
        send_word(bba_pkg::ACT_ALLOC, 32'd65536, 32'd0);             // the whole region
        send_word(bba_pkg::ACT_ALLOC, 32'd1, 32'd0);                 // nothing left
        send_word(bba_pkg::ACT_FREE, 32'd64, 32'd64);                // never granted
        send_word(bba_pkg::ACT_FREE, 32'd65536, 32'd0);              // whole region back
        send_word(bba_pkg::ACT_ALLOC, 32'd64, 32'd0);                // full split to level 0
        send_word(bba_pkg::ACT_ALLOC, 32'd100, 32'd0);
        send_word(bba_pkg::ACT_ALLOC, 32'd1, 32'd0);
        send_word(bba_pkg::ACT_FREE, 32'd64, 32'd32);                // offset off the grid
        send_word(bba_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(bba_pkg::ACT_FREE, 32'd0, 32'd65536);              // offset past the region
        send_word(bba_pkg::ACT_FREE, 32'd65500, 32'd64);             // offset plus size past end
        send_word(bba_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'd0);          // size past the region
        send_word(bba_pkg::ACT_FREE, 32'd64, 32'd0);                 // buddy still held, no merge
        send_word(bba_pkg::ACT_FREE, 32'd64, 32'd0);                 // double free
        send_word(bba_pkg::ACT_FREE, 32'd100, 32'd128);
        send_word(bba_pkg::ACT_FREE, 32'd1, 32'd64);
        send_word(bba_pkg::ACT_ALLOC, 32'd65536, 32'd0);             // region whole again
        drain();

        // Random phases over the pool settings, cycling the idling pattern.
        for (int ph = 0; ph < 8; ph++) begin
            set_pool(log2_set[ph], level_set[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < 160; n++) random_request();
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("buddy_block_allocator regression: pass");
        end else begin
            $display("buddy_block_allocator regression: fail");
        end
        $finish;
    end
endmodule

// ===== buddy_block_allocator.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dp.sv
rtl/core/buddy_block_allocator.sv
rtl/core/bba_checker.sv
verif/buddy_block_allocator_checker.sv
verif/buddy_block_allocator_tb.sv
